[src/dsm_pkg.sv]
// Shared types and constants for the dot-star regex matcher.
package dsm_pkg;

  localparam logic [1:0] CMD_CLEAR   = 2'd0;
  localparam logic [1:0] CMD_APPEND  = 2'd1;
  localparam logic [1:0] CMD_SUBJECT = 2'd2;
  localparam logic [1:0] CMD_END     = 2'd3;

  localparam logic [7:0] CH_ANY  = 8'h2E;
  localparam logic [7:0] CH_STAR = 8'h2A;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_TOO_LONG  = 2'd2;

  typedef struct packed {
    logic       clear;    // empty the element table
    logic       restart;  // live set back to position zero
    logic       wr_char;  // store a literal in the first free element
    logic       wr_star;  // star the last stored element
    logic       step;     // advance the live set by one subject byte
    logic [7:0] ch;
  } cell_ctl_t;

endpackage

[src/dsm_if.sv]
// Valid/ready channel interfaces for pattern/subject input and match results.
interface dsm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] data_char;

  modport source (output valid, output cmd, output data_char, input ready);
  modport sink (input valid, input cmd, input data_char, output ready);
endinterface

interface dsm_out_if;
  logic       valid;
  logic       ready;
  logic       matched;
  logic [1:0] status;

  modport source (output valid, output matched, output status, input ready);
  modport sink (input valid, input matched, input status, output ready);
endinterface

[src/dot_star_regex_matcher_core.sv]
// Top level: whole-string matcher for literal, '.' and '*' patterns.
//
// in_ch carries commands: clear pattern, append pattern byte, subject byte,
// end of subject. Each command is one transfer; the block takes one item
// every cycle, back to back, for every command, while no waiting result holds in_ch.ready low.
// Only end of subject produces a result on out_ch: matched and status
// (ok, malformed star, pattern too long). The result is registered and
// appears in the cycle after the end-of-subject transfer.
// Elements sit in a row of MAX_ELEMS cells; each cell holds one byte, its
// star mark and one live position bit. A subject byte updates every live bit
// at once: the closure over starred elements ripples along the row
// like a carry, then each cell hands its advance bit to its neighbor.
// The result sits in a single output register; in_ch.ready is low only
// while that register is full and out_ch.ready is low, so a stalled
// receiver stalls the input after one waiting result.
// After reset the pattern is empty, status ok and only position zero live;
// no clearing pass is needed.
module dot_star_regex_matcher_core #(
  parameter int MAX_ELEMS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  dsm_in_if.sink    in_ch,
  dsm_out_if.source out_ch
);

  dsm_pkg::cell_ctl_t   ctl_w;
  logic                 in_fire;
  logic [MAX_ELEMS:0]   carry_w;
  logic [MAX_ELEMS:0]   adv_w;
  logic [MAX_ELEMS+1:0] used_ext;
  logic [MAX_ELEMS-1:0] live_w;
  logic [MAX_ELEMS-1:0] hit_w;
  logic [MAX_ELEMS-1:0] lstar_w;
  logic                 tail_live_r, tail_live_nxt;
  logic                 tail_cl;
  logic                 tail_hit;
  logic                 empty_w;
  logic                 full_w;
  logic                 any_hit;
  logic [1:0]           status_r, status_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_matched_r, out_matched_nxt;
  logic [1:0]           out_status_r, out_status_nxt;
  logic                 st_ok;
  logic                 is_star;

  assign in_ch.ready    = ~out_valid_r | out_ch.ready;
  assign in_fire        = in_ch.valid & in_ch.ready;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.matched = out_matched_r;
  assign out_ch.status  = out_status_r;

  assign carry_w[0]            = 1'b0;
  assign adv_w[0]              = 1'b0;
  assign used_ext[0]           = 1'b1;
  assign used_ext[MAX_ELEMS+1] = 1'b0;

  assign empty_w = ~used_ext[1];
  assign full_w  = used_ext[MAX_ELEMS];
  assign st_ok   = (status_r == dsm_pkg::ST_OK);
  assign is_star = (in_ch.data_char == dsm_pkg::CH_STAR);

  always_comb begin
    ctl_w = '0;
    ctl_w.ch = in_ch.data_char;
    if (in_fire) begin
      unique case (in_ch.cmd)
        dsm_pkg::CMD_CLEAR: begin
          ctl_w.clear   = 1'b1;
          ctl_w.restart = 1'b1;
        end
        dsm_pkg::CMD_APPEND: begin
          ctl_w.restart = 1'b1;
          ctl_w.wr_char = st_ok & ~is_star & ~full_w;
          ctl_w.wr_star = st_ok & is_star & ~empty_w & ~(|lstar_w);
        end
        dsm_pkg::CMD_SUBJECT: ctl_w.step = 1'b1;
        dsm_pkg::CMD_END: ctl_w.restart = 1'b1;
        default: ctl_w.restart = 1'b0;
      endcase
    end
  end

  for (genvar i = 0; i < MAX_ELEMS; i++) begin : g_cell
    dsm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl_w),
      .head      (1'(i == 0)),
      .used_prev (used_ext[i]),
      .used_next (used_ext[i+2]),
      .carry_in  (carry_w[i]),
      .adv_in    (adv_w[i]),
      .carry_out (carry_w[i+1]),
      .adv_out   (adv_w[i+1]),
      .used      (used_ext[i+1]),
      .live      (live_w[i]),
      .hit       (hit_w[i]),
      .last_star (lstar_w[i])
    );
  end

  assign tail_cl  = tail_live_r | carry_w[MAX_ELEMS];
  assign tail_hit = tail_cl & used_ext[MAX_ELEMS];
  assign any_hit  = (|hit_w) | tail_hit;

  always_comb begin
    tail_live_nxt   = tail_live_r;
    status_nxt      = status_r;
    out_valid_nxt   = out_valid_r & ~out_ch.ready;
    out_matched_nxt = out_matched_r;
    out_status_nxt  = out_status_r;
    if (ctl_w.restart) begin
      tail_live_nxt = 1'b0;
    end else if (ctl_w.step) begin
      tail_live_nxt = adv_w[MAX_ELEMS];
    end
    if (in_fire) begin
      case (in_ch.cmd)
        dsm_pkg::CMD_CLEAR: status_nxt = dsm_pkg::ST_OK;
        dsm_pkg::CMD_APPEND: begin
          if (st_ok) begin
            if (is_star) begin
              if (empty_w || (|lstar_w)) status_nxt = dsm_pkg::ST_MALFORMED;
            end else if (full_w) begin
              status_nxt = dsm_pkg::ST_TOO_LONG;
            end
          end
        end
        dsm_pkg::CMD_END: begin
          out_valid_nxt   = 1'b1;
          out_matched_nxt = any_hit & st_ok;
          out_status_nxt  = status_r;
        end
        default: status_nxt = status_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_live_r <= 1'b0;
      status_r    <= dsm_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      tail_live_r <= tail_live_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_matched_r <= out_matched_nxt;
    out_status_r  <= out_status_nxt;
  end

`ifndef NO_ASSERTIONS
  a_rose_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_fire && (in_ch.cmd == dsm_pkg::CMD_END)))
    else $error("result without end-of-subject transfer");

  a_match_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_matched_r) |-> (out_status_r == dsm_pkg::ST_OK))
    else $error("match reported with bad pattern status");

  a_used_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((used_ext[MAX_ELEMS:1] >> 1) & ~used_ext[MAX_ELEMS:1]) == '0)
    else $error("occupied elements not contiguous from zero");

  a_append_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_ch.cmd == dsm_pkg::CMD_APPEND))
      |=> (live_w == MAX_ELEMS'(1)) && !tail_live_r)
    else $error("pattern append did not restart the live set");
`endif

endmodule

[src/dsm_cell.sv]
// One pattern element: byte, star mark, occupancy and its live position bit.
module dsm_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  dsm_pkg::cell_ctl_t ctl,
  input  logic              head,
  input  logic              used_prev,
  input  logic              used_next,
  input  logic              carry_in,
  input  logic              adv_in,
  output logic              carry_out,
  output logic              adv_out,
  output logic              used,
  output logic              live,
  output logic              hit,
  output logic              last_star
);

  logic       used_r, used_nxt;
  logic       star_r, star_nxt;
  logic       live_r, live_nxt;
  logic [7:0] char_r, char_nxt;
  logic       cl;
  logic       m;
  logic       slot;

  assign cl        = live_r | carry_in;
  assign carry_out = cl & star_r;
  assign m         = used_r & ((char_r == dsm_pkg::CH_ANY) || (char_r == ctl.ch));
  assign adv_out   = cl & m & ~star_r;
  assign slot      = used_prev & ~used_r;
  assign used      = used_r;
  assign live      = live_r;
  assign hit       = cl & used_prev & ~used_r;
  assign last_star = used_r & ~used_next & star_r;

  always_comb begin
    used_nxt = used_r;
    star_nxt = star_r;
    char_nxt = char_r;
    live_nxt = live_r;
    if (ctl.clear) begin
      used_nxt = 1'b0;
      star_nxt = 1'b0;
    end else if (ctl.wr_char && slot) begin
      used_nxt = 1'b1;
      star_nxt = 1'b0;
      char_nxt = ctl.ch;
    end else if (ctl.wr_star && used_r && !used_next) begin
      star_nxt = 1'b1;
    end
    if (ctl.restart) begin
      live_nxt = head;
    end else if (ctl.step) begin
      live_nxt = (cl & m & star_r) | adv_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      star_r <= 1'b0;
      live_r <= head;
    end else begin
      used_r <= used_nxt;
      star_r <= star_nxt;
      live_r <= live_nxt;
    end
    char_r <= char_nxt;
  end

endmodule

[tb/dsm_match_checker.sv]
// Checker for the dot-star matcher: predicts match results from accepted commands and compares them.
module dsm_match_checker
  import dsm_pkg::*;
#(
  parameter int MAX_ELEMS = 16
) (
  input  logic clk,
  input  logic rst_n,
  dsm_in_if    in_mon,
  dsm_out_if   out_mon,
  output int   mismatches,
  output int   verdicts_pending
);

  typedef struct packed {
    logic       matched;
    logic [1:0] status;
  } verdict_t;

  verdict_t             verdict_q[$];
  logic [7:0]           elem_char [MAX_ELEMS];
  logic [MAX_ELEMS-1:0] elem_star;
  int                   elem_count;
  logic [1:0]           pat_status;
  logic [MAX_ELEMS:0]   live;

  task automatic clear_pattern();
    elem_star  = '0;
    elem_count = 0;
    pat_status = ST_OK;
    live       = (MAX_ELEMS+1)'(1);
  endtask

  // starred elements may match nothing, so liveness ripples past them
  task automatic close_live();
    for (int i = 0; i < elem_count; i++) begin
      if (live[i] && elem_star[i]) live[i+1] = 1'b1;
    end
  endtask

  task automatic add_pattern_byte(input logic [7:0] ch);
    if (pat_status != ST_OK) return;
    if (ch == CH_STAR) begin
      if (elem_count == 0 || elem_star[elem_count-1]) pat_status = ST_MALFORMED;
      else elem_star[elem_count-1] = 1'b1;
    end else if (elem_count >= MAX_ELEMS) begin
      pat_status = ST_TOO_LONG;
    end else begin
      elem_char[elem_count] = ch;
      elem_star[elem_count] = 1'b0;
      elem_count++;
    end
  endtask

  task automatic advance_live(input logic [7:0] ch);
    logic [MAX_ELEMS:0] nxt;
    close_live();
    nxt = '0;
    for (int i = 0; i < elem_count; i++) begin
      if (live[i] && (elem_char[i] == CH_ANY || elem_char[i] == ch)) begin
        if (elem_star[i]) nxt[i] = 1'b1;
        else nxt[i+1] = 1'b1;
      end
    end
    live = nxt;
  endtask

  task automatic apply_command(input logic [1:0] cmd, input logic [7:0] ch);
    verdict_t v;
    case (cmd)
      CMD_CLEAR: clear_pattern();
      CMD_APPEND: begin
        add_pattern_byte(ch);
        live = (MAX_ELEMS+1)'(1);
      end
      CMD_SUBJECT: advance_live(ch);
      default: begin
        close_live();
        v.matched = live[elem_count] && (pat_status == ST_OK);
        v.status  = pat_status;
        verdict_q.push_back(v);
        live = (MAX_ELEMS+1)'(1);
      end
    endcase
  endtask

  task automatic note_mismatch(input string msg);
    if (mismatches < 10) $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    verdict_t got;
    verdict_t want;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready) apply_command(in_mon.cmd, in_mon.data_char);
      if (out_mon.valid && out_mon.ready) begin
        got.matched = out_mon.matched;
        got.status  = out_mon.status;
        if (verdict_q.size() == 0) begin
          note_mismatch($sformatf("result with none expected: matched %0b status %0d",
                                  got.matched, got.status));
        end else begin
          want = verdict_q.pop_front();
          if (got.matched !== want.matched)
            note_mismatch($sformatf("matched: expected %0b, got %0b", want.matched, got.matched));
          if (got.status !== want.status)
            note_mismatch($sformatf("status: expected %0d, got %0d", want.status, got.status));
        end
      end
    end else begin
      mismatches = 0;
      verdict_q.delete();
      clear_pattern();
    end
    verdicts_pending = verdict_q.size();
  end

endmodule

[tb/tb.sv]
// Testbench top: drives patterns and subjects into the dot-star matcher and reports the verdict.
module tb;
  import dsm_pkg::*;

  localparam int MAX_ELEMS       = 16;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int LONG_HOLD       = 300;
  localparam int DRAIN_CYCLES    = 8;

  logic clk;
  logic rst_n;
  int   idle_pct;
  int   stall_pct;
  int   items_sent;
  int   cycles = 0;
  int   mismatches;
  int   verdicts_pending;
  int   hold_req;
  int   hold_seen = 0;
  int   hold_left = 0;

  dsm_in_if  in_ch ();
  dsm_out_if out_ch ();

  dot_star_regex_matcher_core #(.MAX_ELEMS(MAX_ELEMS)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  dsm_match_checker #(.MAX_ELEMS(MAX_ELEMS)) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_mon           (in_ch),
    .out_mon          (out_ch),
    .mismatches       (mismatches),
    .verdicts_pending (verdicts_pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen    <= hold_req;
      hold_left    <= LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic send(input logic [1:0] cmd, input logic [7:0] ch);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= cmd;
    in_ch.data_char <= ch;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  function automatic logic [7:0] pattern_char();
    int r;
    r = $urandom_range(0, 19);
    if (r < 7) return "a";
    if (r < 13) return "b";
    if (r < 18) return CH_ANY;
    if (r == 18) return "c";
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] subject_char();
    int r;
    r = $urandom_range(0, 19);
    if (r < 9) return "a";
    if (r < 16) return "b";
    if (r < 19) return "c";
    return 8'($urandom_range(0, 255));
  endfunction

  // one pattern followed by a few subjects, mostly ones the pattern accepts
  task automatic run_pattern_set();
    logic [7:0] el_ch[$];
    bit         el_st[$];
    int         n;
    int         kind;
    int         bad_at;
    int         reps;
    send(CMD_CLEAR, 8'($urandom_range(0, 255)));
    kind   = $urandom_range(0, 99);
    n      = (kind < 8) ? $urandom_range(15, 18) : $urandom_range(0, 6);
    bad_at = (kind >= 8 && kind < 16) ? $urandom_range(0, n) : -1;
    for (int i = 0; i < n; i++) begin
      el_ch.push_back(pattern_char());
      el_st.push_back($urandom_range(0, 99) < 35);
    end
    for (int i = 0; i <= n; i++) begin
      if (i == bad_at) begin
        send(CMD_APPEND, CH_STAR);
        if (i > 0 && !el_st[i-1]) send(CMD_APPEND, CH_STAR);
      end
      if (i < n) begin
        send(CMD_APPEND, el_ch[i]);
        if (el_st[i]) send(CMD_APPEND, CH_STAR);
      end
    end
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 99) < 60) begin
        for (int i = 0; i < n; i++) begin
          reps = el_st[i] ? $urandom_range(0, 3) : 1;
          repeat (reps) send(CMD_SUBJECT, (el_ch[i] == CH_ANY) ? subject_char() : el_ch[i]);
        end
      end else begin
        repeat ($urandom_range(0, 6)) send(CMD_SUBJECT, subject_char());
      end
      if ($urandom_range(0, 99) < 5) send(CMD_APPEND, pattern_char());
      send(CMD_END, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int target;
    in_ch.valid     = 1'b0;
    in_ch.cmd       = CMD_CLEAR;
    in_ch.data_char = 8'h00;
    rst_n           = 1'b0;
    idle_pct        = 0;
    stall_pct       = 0;
    items_sent      = 0;
    hold_req        = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // empty pattern against empty subject, then against one byte
    send(CMD_END, 8'h00);
    send(CMD_SUBJECT, 8'hFF);
    send(CMD_END, 8'hFF);
    // leading star
    send(CMD_APPEND, CH_STAR);
    send(CMD_END, 8'h00);
    // doubled star, later bytes ignored, subject still streamed
    send(CMD_CLEAR, 8'hFF);
    send(CMD_APPEND, "a");
    send(CMD_APPEND, CH_STAR);
    send(CMD_APPEND, CH_STAR);
    send(CMD_APPEND, "b");
    send(CMD_SUBJECT, "a");
    send(CMD_END, 8'h00);
    // dot-star over extreme bytes
    send(CMD_CLEAR, 8'h00);
    send(CMD_APPEND, CH_ANY);
    send(CMD_APPEND, CH_STAR);
    send(CMD_SUBJECT, 8'h00);
    send(CMD_SUBJECT, 8'hFF);
    send(CMD_END, 8'h00);
    // pattern edit in the middle of a subject restarts it
    send(CMD_SUBJECT, "q");
    send(CMD_APPEND, "x");
    send(CMD_SUBJECT, "x");
    send(CMD_END, 8'hFF);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct = 0;
          stall_pct <= 0;
          hold_req  <= hold_req + 1;
        end
        1: begin
          idle_pct = 76;
          stall_pct <= 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct <= 76;
        end
        default: begin
          idle_pct = 14;
          stall_pct <= 14;
        end
      endcase
      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) run_pattern_set();
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (verdicts_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && verdicts_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
src/dsm_pkg.sv
src/dsm_if.sv
src/dsm_cell.sv
src/dot_star_regex_matcher_core.sv
tb/dsm_match_checker.sv
tb/tb.sv
